### hdl/tml_pkg.sv
// ----------------------------------------------------------------------------
// tml_pkg
// Shared constants for the twist magnitude limiter.
// ----------------------------------------------------------------------------
package tml_pkg;

    localparam int DATA_WIDTH_DEF = 32;  // width of one velocity component
    localparam int LIMIT_WIDTH    = 31;  // speed limit register, unsigned Q15.16
    localparam int LIMIT_LO_WIDTH = 16;  // low slice of the limit in split products
    localparam int NUM_COMP       = 6;   // three linear plus three angular

endpackage

### hdl/tml_sqrt.sv
// ----------------------------------------------------------------------------
// tml_sqrt
// Pipelined integer square root, one root bit per stage.
// ----------------------------------------------------------------------------
module tml_sqrt #(
    parameter int DATA_WIDTH = tml_pkg::DATA_WIDTH_DEF
) (
    input  logic                    clk,
    input  logic                    en,
    input  logic [2*DATA_WIDTH+1:0] s_in,
    output logic [DATA_WIDTH:0]     root
);

    localparam int STEPS = DATA_WIDTH + 1;
    localparam int SW    = 2 * DATA_WIDTH + 2;
    localparam int RW    = DATA_WIDTH + 3;
    localparam int QW    = DATA_WIDTH + 1;

    logic [RW-1:0] rem_reg  [1:STEPS-1];
    logic [SW-1:0] sh_reg   [1:STEPS-1];
    logic [QW-1:0] root_reg [1:STEPS];

    for (genvar k = 0; k < STEPS; k++) begin : g_stage
        logic [RW-1:0] rem_i;
        logic [SW-1:0] sh_i;
        logic [QW-1:0] root_i;
        logic [RW+1:0] r2;
        logic [RW+1:0] trial;
        logic          take;

        if (k == 0) begin : g_first
            assign rem_i  = '0;
            assign sh_i   = s_in;
            assign root_i = '0;
        end else begin : g_rest
            assign rem_i  = rem_reg[k];
            assign sh_i   = sh_reg[k];
            assign root_i = root_reg[k];
        end

        // bring down two radicand bits, try root*4+1
        assign r2    = {rem_i, sh_i[SW-1 -: 2]};
        assign trial = (RW+2)'({root_i, 2'b01});
        assign take  = (r2 >= trial);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                root_reg[k+1] <= {root_i[QW-2:0], take};
            end
        end

        if (k < STEPS - 1) begin : g_carry
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[k+1] <= take ? RW'(r2 - trial) : RW'(r2);
                    sh_reg[k+1]  <= sh_i << 2;
                end
            end
        end
    end

    assign root = root_reg[STEPS];

endmodule

### hdl/tml_div.sv
// ----------------------------------------------------------------------------
// tml_div
// Pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module tml_div #(
    parameter int DATA_WIDTH = tml_pkg::DATA_WIDTH_DEF
) (
    input  logic                                          clk,
    input  logic                                          en,
    input  logic [DATA_WIDTH+tml_pkg::LIMIT_WIDTH-1:0]    num,
    input  logic [DATA_WIDTH:0]                           den,
    output logic [DATA_WIDTH-1:0]                         quo
);

    localparam int STEPS = DATA_WIDTH;
    localparam int RW    = DATA_WIDTH + 2;

    logic [RW-1:0]         rem_reg [1:STEPS-1];
    logic [STEPS-1:0]      sh_reg  [1:STEPS-1];
    logic [STEPS-1:0]      q_reg   [1:STEPS];
    logic [DATA_WIDTH:0]   den_reg [1:STEPS-1];

    for (genvar k = 0; k < STEPS; k++) begin : g_stage
        logic [RW-1:0]         rem_i;
        logic [STEPS-1:0]      sh_i;
        logic [STEPS-1:0]      q_i;
        logic [DATA_WIDTH:0]   d_i;
        logic [RW-1:0]         r2;
        logic                  take;

        if (k == 0) begin : g_first
            // quotient fits DATA_WIDTH bits, so the top part is already below den
            assign rem_i = RW'(num >> STEPS);
            assign sh_i  = num[STEPS-1:0];
            assign q_i   = '0;
            assign d_i   = den;
        end else begin : g_rest
            assign rem_i = rem_reg[k];
            assign sh_i  = sh_reg[k];
            assign q_i   = q_reg[k];
            assign d_i   = den_reg[k];
        end

        assign r2   = {rem_i[RW-2:0], sh_i[STEPS-1]};
        assign take = (r2 >= RW'(d_i));

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                q_reg[k+1] <= {q_i[STEPS-2:0], take};
            end
        end

        if (k < STEPS - 1) begin : g_carry
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[k+1] <= take ? (r2 - RW'(d_i)) : r2;
                    sh_reg[k+1]  <= sh_i << 1;
                    den_reg[k+1] <= d_i;
                end
            end
        end
    end

    assign quo = q_reg[STEPS];

endmodule

### hdl/twist_magnitude_limiter_core.sv
// ----------------------------------------------------------------------------
// twist_magnitude_limiter_core
// Clamps a six-component Q16.16 velocity command to a maximum norm.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one command request per beat, six signed components.
//   m_axis returns one result per command, in order, with the clamp flag
//   on tuser. cfg_wr_en/cfg_wr_data load speed_limit (0 = no clamping);
//   write it only while the block is idle.
// Pipeline: input register, three stages of squares, sums and compare,
//   DATA_WIDTH+1 square-root stages, DATA_WIDTH divider stages and the
//   output register.
// Throughput: one command per cycle while the pipe is not stalled; every stage holds one request.
// Reset: clears all valid bits and speed_limit; payload is not cleared.
// Stall: a held m_axis_tready freezes the whole pipe once the skid register
//   behind the output register fills; s_axis_tready drops in the same cycle,
//   nothing is lost or repeated.
// ----------------------------------------------------------------------------
module twist_magnitude_limiter_core #(
    parameter int DATA_WIDTH = tml_pkg::DATA_WIDTH_DEF
) (
    input  logic clk,
    input  logic rst_n,
    input  logic s_axis_tvalid,
    output logic s_axis_tready,
    // lin_x, lin_y, lin_z, ang_x, ang_y, ang_z, zero pad
    input  logic [((tml_pkg::NUM_COMP*DATA_WIDTH+7)/8)*8-1:0] s_axis_tdata,
    output logic m_axis_tvalid,
    input  logic m_axis_tready,
    // out_lin_x, out_lin_y, out_lin_z, out_ang_x, out_ang_y, out_ang_z, zero pad
    output logic [((tml_pkg::NUM_COMP*DATA_WIDTH+7)/8)*8-1:0] m_axis_tdata,
    // was_clamped
    output logic m_axis_tuser,
    input  logic cfg_wr_en,
    input  logic [tml_pkg::LIMIT_WIDTH-1:0] cfg_wr_data
);

    localparam int W     = DATA_WIDTH;
    localparam int NC    = tml_pkg::NUM_COMP;
    localparam int CW    = NC * W;
    localparam int TDW   = ((CW + 7) / 8) * 8;
    localparam int H     = (W + 1) / 2;
    localparam int L     = W - H;
    localparam int LLW   = 2 * H;
    localparam int LHW   = H + L;
    localparam int HHW   = 2 * L;
    localparam int SQW   = 2 * W;
    localparam int SUMW  = 2 * W + 2;
    localparam int LW    = tml_pkg::LIMIT_WIDTH;
    localparam int LLO   = tml_pkg::LIMIT_LO_WIDTH;
    localparam int LHI   = LW - LLO;
    localparam int L2W   = 2 * LW;
    localparam int CMPW  = (SUMW > L2W) ? SUMW : L2W;
    localparam int NUMW  = W + LW;
    localparam int NLW   = W + LLO;
    localparam int NHW   = W + LHI;
    localparam int SQLAT = W + 1;
    localparam int SDLAT = SQLAT + W;
    localparam int SIDEW = 1 + NC + CW;

    logic [LW-1:0] limit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            limit_reg <= cfg_wr_data;
        end
    end

    logic en;
    logic skid_valid_reg;

    assign en            = !skid_valid_reg;
    assign s_axis_tready = en;

    // ---------------- stage 0: input register ----------------
    logic          p0_valid_reg;
    logic [CW-1:0] p0_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p0_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            p0_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p0_data_reg <= s_axis_tdata[CW-1:0];
        end
    end

    logic [W-1:0] mag [NC];
    logic [NC-1:0] neg;

    always_comb
    begin
        for (int c = 0; c < NC; c++)
        begin
            neg[c] = p0_data_reg[c*W + W - 1];
            mag[c] = neg[c] ? (~p0_data_reg[c*W +: W] + W'(1)) : p0_data_reg[c*W +: W];
        end
    end

    // ---------------- stage 1: partial products ----------------
    logic           p1_valid_reg;
    logic [CW-1:0]  p1_data_reg;
    logic [NC-1:0]  p1_neg_reg;
    logic [LLW-1:0] p1_ll_reg  [NC];
    logic [LHW-1:0] p1_lh_reg  [NC];
    logic [HHW-1:0] p1_hh_reg  [NC];
    logic [NLW-1:0] p1_nlo_reg [NC];
    logic [NHW-1:0] p1_nhi_reg [NC];
    logic [L2W-1:0] p1_lim2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            p1_valid_reg <= p0_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p1_data_reg <= p0_data_reg;
            p1_neg_reg  <= neg;
            p1_lim2_reg <= L2W'(limit_reg) * L2W'(limit_reg);
            for (int c = 0; c < NC; c++)
            begin
                p1_ll_reg[c]  <= LLW'(mag[c][H-1:0]) * LLW'(mag[c][H-1:0]);
                p1_lh_reg[c]  <= LHW'(mag[c][H-1:0]) * LHW'(mag[c][W-1:H]);
                p1_hh_reg[c]  <= HHW'(mag[c][W-1:H]) * HHW'(mag[c][W-1:H]);
                p1_nlo_reg[c] <= NLW'(mag[c]) * NLW'(limit_reg[LLO-1:0]);
                p1_nhi_reg[c] <= NHW'(mag[c]) * NHW'(limit_reg[LW-1:LLO]);
            end
        end
    end

    // ---------------- stage 2: squares, triple sums, numerators ----------------
    logic [SQW-1:0] sq [NC];

    always_comb
    begin
        for (int c = 0; c < NC; c++)
        begin
            sq[c] = (SQW'(p1_hh_reg[c]) << (2 * H)) + (SQW'(p1_lh_reg[c]) << (H + 1))
                  + SQW'(p1_ll_reg[c]);
        end
    end

    logic            p2_valid_reg;
    logic [CW-1:0]   p2_data_reg;
    logic [NC-1:0]   p2_neg_reg;
    logic [SUMW-1:0] p2_lin_reg;
    logic [SUMW-1:0] p2_ang_reg;
    logic [NUMW-1:0] p2_num_reg [NC];
    logic [L2W-1:0]  p2_lim2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p2_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            p2_valid_reg <= p1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p2_data_reg <= p1_data_reg;
            p2_neg_reg  <= p1_neg_reg;
            p2_lim2_reg <= p1_lim2_reg;
            p2_lin_reg  <= SUMW'(sq[0]) + SUMW'(sq[1]) + SUMW'(sq[2]);
            p2_ang_reg  <= SUMW'(sq[3]) + SUMW'(sq[4]) + SUMW'(sq[5]);
            for (int c = 0; c < NC; c++)
            begin
                p2_num_reg[c] <= NUMW'(p1_nlo_reg[c]) + (NUMW'(p1_nhi_reg[c]) << LLO);
            end
        end
    end

    // ---------------- stage 3: larger norm, clamp decision ----------------
    logic [SUMW-1:0] s_max;
    logic            clamp;

    assign s_max = (p2_ang_reg > p2_lin_reg) ? p2_ang_reg : p2_lin_reg;
    assign clamp = (p2_lim2_reg != '0) && (CMPW'(s_max) > CMPW'(p2_lim2_reg));

    logic             p3_valid_reg;
    logic [SIDEW-1:0] p3_side_reg;
    logic [SUMW-1:0]  p3_s_reg;
    logic [NUMW-1:0]  p3_num_reg [NC];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p3_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            p3_valid_reg <= p2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p3_side_reg <= {clamp, p2_neg_reg, p2_data_reg};
            p3_s_reg    <= s_max;
            p3_num_reg  <= p2_num_reg;
        end
    end

    // ---------------- square root and side delay lines ----------------
    logic [W:0] root;

    tml_sqrt #(
        .DATA_WIDTH(W)
    ) u_sqrt (
        .clk (clk),
        .en  (en),
        .s_in(p3_s_reg),
        .root(root)
    );

    logic             sd_valid_reg [1:SDLAT];
    logic [SIDEW-1:0] sd_side_reg  [1:SDLAT];
    logic [NUMW-1:0]  nd_num_reg   [1:SQLAT][NC];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 1; k <= SDLAT; k++)
            begin
                sd_valid_reg[k] <= 1'b0;
            end
        end
        else if (en)
        begin
            sd_valid_reg[1] <= p3_valid_reg;
            for (int k = 2; k <= SDLAT; k++)
            begin
                sd_valid_reg[k] <= sd_valid_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sd_side_reg[1] <= p3_side_reg;
            for (int k = 2; k <= SDLAT; k++)
            begin
                sd_side_reg[k] <= sd_side_reg[k-1];
            end
            nd_num_reg[1] <= p3_num_reg;
            for (int k = 2; k <= SQLAT; k++)
            begin
                nd_num_reg[k] <= nd_num_reg[k-1];
            end
        end
    end

    // ---------------- dividers, one per component ----------------
    logic [W-1:0] quo [NC];

    for (genvar c = 0; c < NC; c++) begin : g_div
        tml_div #(
            .DATA_WIDTH(W)
        ) u_div (
            .clk(clk),
            .en (en),
            .num(nd_num_reg[SQLAT][c]),
            .den(root),
            .quo(quo[c])
        );
    end

    // ---------------- result assembly ----------------
    logic             f_valid;
    logic [SIDEW-1:0] f_side;
    logic             f_clamp;
    logic [NC-1:0]    f_neg;
    logic [CW-1:0]    f_data;
    logic [CW-1:0]    res_data;

    assign f_valid = sd_valid_reg[SDLAT];
    assign f_side  = sd_side_reg[SDLAT];
    assign f_clamp = f_side[SIDEW-1];
    assign f_neg   = f_side[CW +: NC];
    assign f_data  = f_side[CW-1:0];

    always_comb
    begin
        for (int c = 0; c < NC; c++)
        begin
            if (f_clamp)
            begin
                res_data[c*W +: W] = f_neg[c] ? (~quo[c] + W'(1)) : quo[c];
            end
            else
            begin
                res_data[c*W +: W] = f_data[c*W +: W];
            end
        end
    end

    // ---------------- output register with skid ----------------
    logic          out_valid_reg;
    logic [CW-1:0] out_data_reg;
    logic          out_user_reg;
    logic [CW-1:0] skid_data_reg;
    logic          skid_user_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (m_axis_tready)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (!out_valid_reg || m_axis_tready)
        begin
            out_valid_reg <= f_valid;
        end
        else if (f_valid)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (m_axis_tready)
            begin
                out_data_reg <= skid_data_reg;
                out_user_reg <= skid_user_reg;
            end
        end
        else if (!out_valid_reg || m_axis_tready)
        begin
            out_data_reg <= res_data;
            out_user_reg <= f_clamp;
        end
        else
        begin
            skid_data_reg <= res_data;
            skid_user_reg <= f_clamp;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = TDW'(out_data_reg);
    assign m_axis_tuser  = out_user_reg;

endmodule
